@@ sv/dtf_pkg.sv @@
// Package: shared types and constants for the DER TLV type finder.
`default_nettype none
package dtf_pkg;
    typedef enum logic [2:0] {
        PH_IDLE, PH_TAG, PH_NULL, PH_OIDLEN, PH_LEN1, PH_LENN, PH_SKIP
    } t_phase;

    typedef enum logic [3:0] {
        ST_FOUND = 4'd0, ST_NOT_FOUND = 4'd1, ST_TRUNC_TAG = 4'd2, ST_BAD_NULL = 4'd3,
        ST_OID_OVERRUN = 4'd4, ST_PRIM_LEN_BAD = 4'd5, ST_CONTENT_OVERRUN = 4'd6,
        ST_CONS_LEN_BAD = 4'd7, ST_UNKNOWN_TYPE = 4'd8
    } t_status;

    typedef enum logic [1:0] {KIND_OTHER, KIND_PRIM, KIND_CONS} t_kind;

    localparam logic [5:0] TAG_NULL = 6'h05;
    localparam logic [5:0] TAG_OID  = 6'h06;
    localparam logic [5:0] TAG_22   = 6'h22;

    typedef struct packed {
        t_status     status;
        logic [31:0] position;
        logic [31:0] content_length;
        logic [5:0]  bad_type;
    } t_result;

    function automatic t_kind kind_of(input logic [5:0] t);
        unique case (t)
            6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h0A, 6'h0C, 6'h13, 6'h14,
            6'h16, 6'h17, 6'h18, 6'h1E: kind_of = KIND_PRIM;
            6'h20, 6'h21, 6'h23, 6'h24, 6'h30, 6'h31: kind_of = KIND_CONS;
            default: kind_of = KIND_OTHER;
        endcase
    endfunction
endpackage
`default_nettype wire

@@ sv/dtf_scan.sv @@
// Front part: per-byte TLV header walk, produces at most one result per byte.
`default_nettype none
module dtf_scan #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_start_req,
    input  wire logic [5:0]      i_search_type,
    input  wire logic [31:0]     i_region_length,
    input  wire logic [7:0]      i_data_byte,
    output dtf_pkg::t_result     o_result,
    output logic                 o_result_valid
);
    localparam int NW = $clog2(MAX_LENGTH_BYTES + 1);

    dtf_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_pos, n_pos, r_size, n_size, r_acc, n_acc, r_skip, n_skip;
    logic [5:0]  r_want, n_want, r_tag, n_tag;
    logic [NW-1:0] r_left, n_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dtf_pkg::PH_IDLE;
            r_pos <= '0; r_size <= '0; r_acc <= '0; r_skip <= '0;
            r_want <= '0; r_tag <= '0; r_left <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_pos <= n_pos; r_size <= n_size; r_acc <= n_acc; r_skip <= n_skip;
            r_want <= n_want; r_tag <= n_tag; r_left <= n_left;
        end
    end

    always_comb begin
        logic [31:0] p, rem, q, len, acc8;
        logic [6:0]  n;
        logic        fin, adv;
        dtf_pkg::t_phase ph;
        n_phase = r_phase; n_pos = r_pos; n_size = r_size; n_acc = r_acc;
        n_skip = r_skip; n_want = r_want; n_tag = r_tag; n_left = r_left;
        o_result_valid = 1'b0;
        o_result = '{dtf_pkg::ST_NOT_FOUND, 32'd0, 32'd0, 6'd0};
        fin = 1'b0; adv = 1'b0; len = '0; n = i_data_byte[6:0];
        acc8 = {r_acc[23:0], i_data_byte};
        ph = r_phase;
        if (i_start_req) begin
            n_want = i_search_type; n_size = i_region_length;
            n_pos = '0; n_tag = '0; n_acc = '0; n_left = '0; n_skip = '0;
            ph = dtf_pkg::PH_TAG;
            n_phase = dtf_pkg::PH_TAG;
        end
        p = i_start_req ? 32'd0 : r_pos;
        rem = n_size - p;
        q = p + 32'd1;
        if (i_start_req && i_region_length == 32'd0) begin
            o_result_valid = 1'b1;
        end else if (ph != dtf_pkg::PH_IDLE) begin
            if (p >= n_size) begin
                o_result_valid = 1'b1;
            end else begin
                unique case (ph)
                    dtf_pkg::PH_TAG: begin
                        if (rem < 32'd2) begin
                            o_result_valid = 1'b1;
                            o_result = '{dtf_pkg::ST_TRUNC_TAG, p, 32'd0, 6'd0};
                        end else begin
                            n_tag = i_data_byte[5:0];
                            adv = 1'b1;
                            if (n_tag == dtf_pkg::TAG_NULL) n_phase = dtf_pkg::PH_NULL;
                            else if (n_tag == dtf_pkg::TAG_OID) n_phase = dtf_pkg::PH_OIDLEN;
                            else if (dtf_pkg::kind_of(n_tag) != dtf_pkg::KIND_OTHER)
                                n_phase = dtf_pkg::PH_LEN1;
                            else if (n_tag == dtf_pkg::TAG_22) begin
                                n_skip = 32'd1; n_phase = dtf_pkg::PH_SKIP;
                            end else begin
                                adv = 1'b0;
                                o_result_valid = 1'b1;
                                o_result = '{dtf_pkg::ST_UNKNOWN_TYPE, p, 32'd0, n_tag};
                            end
                        end
                    end
                    dtf_pkg::PH_NULL: begin
                        if (i_data_byte != 8'd0) begin
                            o_result_valid = 1'b1;
                            o_result = '{dtf_pkg::ST_BAD_NULL, p, 32'd0, 6'd0};
                        end else begin
                            n_phase = dtf_pkg::PH_TAG; adv = 1'b1;
                        end
                    end
                    dtf_pkg::PH_OIDLEN: begin
                        if ({24'd0, i_data_byte} > rem - 32'd1) begin
                            o_result_valid = 1'b1;
                            o_result = '{dtf_pkg::ST_OID_OVERRUN, p, 32'd0, 6'd0};
                        end else begin
                            n_skip = {24'd0, i_data_byte};
                            n_phase = (i_data_byte != 8'd0) ? dtf_pkg::PH_SKIP
                                                             : dtf_pkg::PH_TAG;
                            adv = 1'b1;
                        end
                    end
                    dtf_pkg::PH_LEN1: begin
                        if (!i_data_byte[7]) begin
                            fin = 1'b1; len = {24'd0, i_data_byte};
                        end else if ({25'd0, n} > rem - 32'd1 ||
                                     {25'd0, n} > 32'(MAX_LENGTH_BYTES)) begin
                            o_result_valid = 1'b1;
                            o_result = '{(dtf_pkg::kind_of(r_tag) == dtf_pkg::KIND_CONS)
                                         ? dtf_pkg::ST_CONS_LEN_BAD
                                         : dtf_pkg::ST_PRIM_LEN_BAD, p, 32'd0, 6'd0};
                        end else if (n == 7'd0) begin
                            fin = 1'b1;
                        end else begin
                            n_acc = '0; n_left = NW'(n - 7'd1);
                            n_phase = dtf_pkg::PH_LENN; adv = 1'b1;
                        end
                    end
                    dtf_pkg::PH_LENN: begin
                        n_acc = acc8;
                        if (r_left == '0) begin
                            fin = 1'b1; len = acc8;
                        end else begin
                            n_left = r_left - NW'(1); adv = 1'b1;
                        end
                    end
                    dtf_pkg::PH_SKIP: begin
                        n_skip = (r_skip != 32'd0) ? r_skip - 32'd1 : r_skip;
                        if (n_skip == 32'd0) n_phase = dtf_pkg::PH_TAG;
                        adv = 1'b1;
                    end
                    default: begin
                        n_phase = dtf_pkg::PH_IDLE;
                    end
                endcase
                if (fin) begin
                    adv = 1'b1;
                    if (dtf_pkg::kind_of(r_tag) == dtf_pkg::KIND_CONS) begin
                        n_phase = dtf_pkg::PH_TAG;
                    end else if (len > n_size - q) begin
                        adv = 1'b0; o_result_valid = 1'b1;
                        o_result = '{dtf_pkg::ST_CONTENT_OVERRUN, q, 32'd0, 6'd0};
                    end else if (r_tag == r_want) begin
                        adv = 1'b0; o_result_valid = 1'b1;
                        o_result = '{dtf_pkg::ST_FOUND, q, len, 6'd0};
                    end else if (len == 32'd0) begin
                        n_phase = dtf_pkg::PH_TAG;
                    end else begin
                        n_skip = len; n_phase = dtf_pkg::PH_SKIP;
                    end
                end
                if (adv) begin
                    n_pos = q;
                    if (n_phase == dtf_pkg::PH_TAG && q >= n_size) o_result_valid = 1'b1;
                end
            end
        end
        if (o_result_valid) n_phase = dtf_pkg::PH_IDLE;
    end
endmodule
`default_nettype wire

@@ sv/dtf_queue.sv @@
// Back part: small result queue that drives the output stream.
`default_nettype none
module dtf_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire dtf_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_tvalid,
    input  wire logic         i_tready,
    output dtf_pkg::t_result  o_result
);
    dtf_pkg::t_result r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic pop;

    assign pop      = o_tvalid && i_tready;
    assign o_tvalid = r_cnt != 2'd0;
    assign o_ready  = r_cnt != 2'd2;
    assign o_result = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

@@ sv/der_tlv_type_finder.sv @@
// Top level: DER TLV type finder, byte stream in, one result per region out.
// A result is registered in the result queue when the byte that decides it is accepted.
// Throughput: one byte per cycle while the queue has room; the scanner decides each byte combinationally.
// A two-entry result queue decouples the output; input stalls only when it is full.
// Reset (synchronous, active low) returns the scanner to idle and empties the queue.
`default_nettype none
module der_tlv_type_finder #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // search_type[5:0], region_length[37:6], data_byte[45:38]
    input  wire logic        s_axis_tuser,  // start_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata   // status[3:0], position[35:4], content_length[67:36], bad_type[73:68]
);
    dtf_pkg::t_result res, qres;
    logic res_v, acc;

    assign acc = s_axis_tvalid && s_axis_tready;

    dtf_scan #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_scan (
        .i_clk, .i_rst_n, .i_valid(acc), .i_start_req(s_axis_tuser),
        .i_search_type(s_axis_tdata[5:0]), .i_region_length(s_axis_tdata[37:6]),
        .i_data_byte(s_axis_tdata[45:38]), .o_result(res), .o_result_valid(res_v)
    );

    dtf_queue u_queue (
        .i_clk, .i_rst_n, .i_push(acc && res_v), .i_result(res),
        .o_ready(s_axis_tready), .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready), .o_result(qres)
    );

    assign m_axis_tdata = {6'd0, qres.bad_type, qres.content_length, qres.position,
                           qres.status};

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8) else $error("bad status");
    a_bad_type_only_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3:0] != dtf_pkg::ST_UNKNOWN_TYPE)
        |-> m_axis_tdata[73:68] == 6'd0) else $error("bad_type set");
    a_zero_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s_axis_tuser && s_axis_tdata[37:6] == 32'd0) |-> res_v)
        else $error("missing not-found");
endmodule
`default_nettype wire
